@@ rtl/key_matrix_scan_debounce_assert.svh @@
// Assertion macros for the key matrix scan and debounce block.
// Used by files that assert; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KMSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key matrix assertion failed");

// Next-cycle implication, checked out of reset.
`define KMSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key matrix assertion failed");

`endif

@@ rtl/kmsd_pkg.sv @@
// Package for the key matrix scan and debounce block: item types, defaults,
// joystick positions and a population count. No dependencies.
package kmsd_pkg;

    localparam int unsigned ROWS_DEF = 20;
    localparam int unsigned COLS_DEF = 8;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;
    localparam int unsigned NUM_STICK = 6;

    // Joystick bit order: up, down, left, right, button right, button left
    localparam int unsigned STICK_COL [NUM_STICK] = '{0, 0, 6, 1, 0, 7};
    localparam int unsigned STICK_ROW [NUM_STICK] = '{16, 15, 0, 19, 0, 1};

    typedef struct packed {
        logic [2:0]  column;
        logic [19:0] row_bits;
        logic        end_of_scan;
        logic [4:0]  query_row;
        logic [2:0]  query_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] stable_row_bits;
        logic       stable_key_on;
        logic       settled;
        logic [7:0] pressed_count;
        logic       stick_up;
        logic       stick_down;
        logic       stick_left;
        logic       stick_right;
        logic       button_right;
        logic       button_left;
    } t_out_item;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            n = n + 6'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ rtl/key_matrix_scan_debounce.sv @@
// An accepted item is taken into the input register, and its result into the result
// register that drives o_out. Throughput: one item per cycle while the output is not
// stalled; the column update, debounce countdown and query all sit between these registers.
// The pressed count is kept as a running register, not summed over the matrix.
// Reset (synchronous, active low): matrices clear, quiet counter and debounce
// setting go to 10, joystick bits clear; ready again the cycle after reset.
`include "key_matrix_scan_debounce_assert.svh"

module key_matrix_scan_debounce #(
    parameter int unsigned ROWS = kmsd_pkg::ROWS_DEF,
    parameter int unsigned COLS = kmsd_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kmsd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kmsd_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import kmsd_pkg::*;

    localparam int unsigned CNTW = $clog2(ROWS * COLS + 1);
    localparam int unsigned QCOLS = (COLS < 8) ? COLS : 8;

    // Control and state
    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic [ROWS-1:0]       r_raw    [COLS];
    logic [ROWS-1:0]       r_stable [COLS];
    logic [CNTW-1:0]       r_raw_count;
    logic [CNTW-1:0]       r_stable_count;
    logic [7:0]            r_quiet;
    logic [7:0]            r_debounce;
    logic [NUM_STICK-1:0]  r_stick;

    logic [ROWS-1:0]       n_raw    [COLS];
    logic [ROWS-1:0]       n_stable [COLS];
    logic [CNTW-1:0]       n_raw_count;
    logic [CNTW-1:0]       n_stable_count;
    logic [7:0]            n_quiet;
    logic [NUM_STICK-1:0]  n_stick;
    t_out_item             n_out;

    logic                  advance;
    logic [ROWS+19:0]      bits_ext;
    logic [ROWS-1:0]       bits_new;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Drop row bits beyond the matrix, pad missing ones with zero
    assign bits_ext = {{ROWS{1'b0}}, r_in.row_bits};
    assign bits_new = bits_ext[ROWS-1:0];

    always_comb begin
        logic            col_ok;
        logic            hit;
        logic            changed;
        logic [ROWS-1:0] old_bits;
        logic [ROWS-1:0] sh;
        logic [7:0]      q1;
        logic            copy;
        logic [7:0]      row_out;
        logic            key_on;
        logic [31:0]     w_old;
        logic [31:0]     w_new;

        sh       = '0;
        hit      = 1'b0;
        col_ok   = 32'(r_in.column) < COLS;
        old_bits = '0;
        for (int c = 0; c < COLS; c++) begin
            if (32'(r_in.column) == c) begin
                old_bits = r_raw[c];
            end
        end
        changed = col_ok && (old_bits != bits_new);

        n_stick = r_stick;
        for (int s = 0; s < NUM_STICK; s++) begin
            hit = col_ok && (32'(r_in.column) == STICK_COL[s]) && (STICK_ROW[s] < ROWS);
            if (hit) begin
                sh = bits_new >> STICK_ROW[s];
                n_stick[s] = sh[0];
            end
        end

        for (int c = 0; c < COLS; c++) begin
            n_raw[c] = (changed && (32'(r_in.column) == c)) ? bits_new : r_raw[c];
        end

        // Running count of pressed raw keys: swap the column's old count for the new
        w_old = 32'(old_bits);
        w_new = 32'(bits_new);
        n_raw_count = r_raw_count;
        if (changed) begin
            n_raw_count = r_raw_count + CNTW'(popcount32(w_new)) - CNTW'(popcount32(w_old));
        end

        // Reload first, then the end of scan countdown
        q1      = changed ? r_debounce : r_quiet;
        n_quiet = q1;
        copy    = 1'b0;
        if (r_in.end_of_scan && (q1 != 8'd0)) begin
            n_quiet = q1 - 8'd1;
            copy    = (n_quiet == 8'd0);
        end

        for (int c = 0; c < COLS; c++) begin
            n_stable[c] = copy ? n_raw[c] : r_stable[c];
        end
        n_stable_count = copy ? n_raw_count : r_stable_count;

        row_out = '0;
        key_on  = 1'b0;
        if (32'(r_in.query_row) < ROWS) begin
            for (int c = 0; c < QCOLS; c++) begin
                sh = n_stable[c] >> r_in.query_row;
                row_out[c] = sh[0];
            end
            for (int c = 0; c < COLS; c++) begin
                if (32'(r_in.query_col) == c) begin
                    sh = n_stable[c] >> r_in.query_row;
                    key_on = sh[0];
                end
            end
        end

        n_out.stable_row_bits = row_out;
        n_out.stable_key_on   = key_on;
        n_out.settled         = (n_quiet == 8'd0);
        n_out.pressed_count   = (32'(n_stable_count) > 255) ? 8'd255 : 8'(n_stable_count);
        n_out.stick_up        = n_stick[0];
        n_out.stick_down      = n_stick[1];
        n_out.stick_left      = n_stick[2];
        n_out.stick_right     = n_stick[3];
        n_out.button_right    = n_stick[4];
        n_out.button_left     = n_stick[5];
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_raw_count    <= '0;
            r_stable_count <= '0;
            r_quiet        <= DEBOUNCE_RESET;
            r_debounce     <= DEBOUNCE_RESET;
            r_stick        <= '0;
            for (int c = 0; c < COLS; c++) begin
                r_raw[c]    <= '0;
                r_stable[c] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_raw_count    <= n_raw_count;
                r_stable_count <= n_stable_count;
                r_quiet        <= n_quiet;
                r_stick        <= n_stick;
                for (int c = 0; c < COLS; c++) begin
                    r_raw[c]    <= n_raw[c];
                    r_stable[c] <= n_stable[c];
                end
            end
            // A zero setting would never let the matrix settle: hold at one
            if (i_cfg_valid) begin
                r_debounce <= (i_cfg_data == 8'd0) ? 8'd1 : i_cfg_data;
            end
        end
    end

    `KMSD_ASSERT_NOW(a_settled_matches, r_quiet == 8'd0, r_stable_count == r_raw_count)
    `KMSD_ASSERT_NOW(a_debounce_nonzero, 1'b1, r_debounce != 8'd0)
    `KMSD_ASSERT_NOW(a_count_bound, 1'b1, 32'(r_raw_count) <= ROWS * COLS)
    `KMSD_ASSERT_NEXT(a_item_held, r_in_valid && !advance, r_in_valid)

endmodule
